// ===== src/tdd_pkg.sv =====
// Shared constants, codes and tables for the trajectory deflection detector.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
package tdd_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int TIME_BITS_DEF  = 32;

   // configuration port
   localparam int CFG_BITS     = 16;
   localparam int CSR_IDX_BITS = 8;
   localparam logic [CSR_IDX_BITS-1:0] REG_ANGLE_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_POINT_COUNT = 8'd1;

   localparam logic [15:0] THRESH_RESET = 16'd1280;
   localparam logic [15:0] MINPTS_RESET = 16'd8;
   localparam logic [15:0] ANGLE_MAX    = 16'd46080;
   localparam logic [15:0] CONF_ONE     = 16'd32768;

   // scaled components stay below 2^SCALE_BITS
   localparam int SCALE_BITS   = 15;
   localparam int CORDIC_STEPS = 16;

   // angle accumulator, Q8.16 degrees
   localparam int ACC_BITS = 25;
   localparam logic signed [ACC_BITS-1:0] ACC_90  = 25'sd5898240;
   localparam logic signed [ACC_BITS-1:0] ACC_180 = 25'sd11796480;

   typedef logic [1:0] sign_type;
   localparam sign_type SIGN_NONE = 2'd0;
   localparam sign_type SIGN_POS  = 2'd1;
   localparam sign_type SIGN_NEG  = 2'd2;

   // atan(2^-k) in Q8.16 degrees
   function automatic logic [ACC_BITS-1:0] atan_entry(input logic [3:0] k);
      logic [ACC_BITS-1:0] v;
      case (k)
         4'd0:    v = 25'd2949120;
         4'd1:    v = 25'd1740967;
         4'd2:    v = 25'd919879;
         4'd3:    v = 25'd466945;
         4'd4:    v = 25'd234379;
         4'd5:    v = 25'd117304;
         4'd6:    v = 25'd58666;
         4'd7:    v = 25'd29335;
         4'd8:    v = 25'd14668;
         4'd9:    v = 25'd7334;
         4'd10:   v = 25'd3667;
         4'd11:   v = 25'd1833;
         4'd12:   v = 25'd917;
         4'd13:   v = 25'd458;
         4'd14:   v = 25'd229;
         default: v = 25'd115;
      endcase
      return v;
   endfunction

endpackage

// ===== src/tdd_if.sv =====
// Valid/ready channel interfaces: point input, result output, register write.
// Depends on tdd_pkg for the default and CSR widths.
`timescale 1ns / 1ps
interface tdd_req_if #(
   parameter int TIME_BITS  = tdd_pkg::TIME_BITS_DEF,
   parameter int COORD_BITS = tdd_pkg::COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic [TIME_BITS-1:0]         sample_time;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   logic                         last_point;
   modport source (output valid, sample_time, pos_x, pos_y, pos_z, last_point, input ready);
   modport sink   (input valid, sample_time, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

interface tdd_rsp_if #(
   parameter int TIME_BITS = tdd_pkg::TIME_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   logic                 anomaly_found;
   logic [TIME_BITS-1:0] anomaly_stamp;
   logic [15:0]          anomaly_angle;
   logic                 anomaly_kind;
   logic [15:0]          confidence;
   modport source (output valid, anomaly_found, anomaly_stamp, anomaly_angle, anomaly_kind,
                   confidence, input ready);
   modport sink   (input valid, anomaly_found, anomaly_stamp, anomaly_angle, anomaly_kind,
                   confidence, output ready);
endinterface

interface tdd_csr_if ();
   logic                               valid;
   logic                               ready;
   logic [tdd_pkg::CSR_IDX_BITS-1:0]   index;
   logic [tdd_pkg::CFG_BITS-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tdd_angle.sv =====
// Angle between two step vectors in Q8.8 degrees: scale, one shared 32x32
// multiplier, bit-pair square root, CORDIC vectoring. Depends on tdd_pkg.
`timescale 1ns / 1ps
module tdd_angle #(
   parameter int COORD_BITS = tdd_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [COORD_BITS:0] base_vec [3],
   input  logic signed [COORD_BITS:0] step_vec [3],
   output logic                    done,
   output logic [15:0]             angle
);
   import tdd_pkg::*;

   localparam int VW = COORD_BITS + 1;
   localparam int MW = (VW > SCALE_BITS + 1) ? VW : SCALE_BITS + 1;
   localparam int DW = 34;   // dot product
   localparam int XW = 36;   // CORDIC x/y

   localparam logic [2:0] A_IDLE   = 3'd0;
   localparam logic [2:0] A_SCALE  = 3'd1;
   localparam logic [2:0] A_MUL    = 3'd2;
   localparam logic [2:0] A_SQRT   = 3'd3;
   localparam logic [2:0] A_CORDIC = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic [MW-1:0]            ma_ff [3], ma_in [3], mb_ff [3], mb_in [3];
   logic                     nega_ff [3], nega_in [3], negb_ff [3], negb_in [3];
   logic signed [15:0]       sa [3], sb [3];
   logic signed [31:0]       opa, opb;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [DW-1:0]     dot_ff, dot_in;
   logic signed [31:0]       t_ff, t_in, c_ff [3], c_in [3];
   logic [63:0]              sq_ff, sq_in, sq_sum;
   logic [63:0]              n_ff, n_in, res_ff, res_in, bit_ff, bit_in;
   logic [64:0]              trial;
   logic signed [XW-1:0]     x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in, acc_cl, acc_fold;
   logic [ACC_BITS-1:0]      acc_rnd;
   logic                     neg_ff, neg_in;
   logic [15:0]              angle_ff, angle_in;
   logic                     done_ff, done_in;
   logic                     need_a, need_b;

   always_comb begin
      need_a = 1'b0;
      need_b = 1'b0;
      for (int k = 0; k < 3; k++) begin
         need_a = need_a | (|ma_ff[k][MW-1:SCALE_BITS]);
         need_b = need_b | (|mb_ff[k][MW-1:SCALE_BITS]);
         sa[k]  = nega_ff[k] ? -$signed(ma_ff[k][15:0]) : $signed(ma_ff[k][15:0]);
         sb[k]  = negb_ff[k] ? -$signed(mb_ff[k][15:0]) : $signed(mb_ff[k][15:0]);
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      case (cnt_ff[3:0])
         4'd0:    begin opa = 32'(sa[0]); opb = 32'(sb[0]); end
         4'd1:    begin opa = 32'(sa[1]); opb = 32'(sb[1]); end
         4'd2:    begin opa = 32'(sa[2]); opb = 32'(sb[2]); end
         4'd3:    begin opa = 32'(sa[1]); opb = 32'(sb[2]); end
         4'd4:    begin opa = 32'(sa[2]); opb = 32'(sb[1]); end
         4'd5:    begin opa = 32'(sa[2]); opb = 32'(sb[0]); end
         4'd6:    begin opa = 32'(sa[0]); opb = 32'(sb[2]); end
         4'd7:    begin opa = 32'(sa[0]); opb = 32'(sb[1]); end
         4'd8:    begin opa = 32'(sa[1]); opb = 32'(sb[0]); end
         4'd9:    begin opa = c_ff[0];    opb = c_ff[0];    end
         4'd10:   begin opa = c_ff[1];    opb = c_ff[1];    end
         4'd11:   begin opa = c_ff[2];    opb = c_ff[2];    end
         default: begin opa = '0;         opb = '0;         end
      endcase
   end

   assign prod_in = 64'(opa) * 64'(opb);
   assign sq_sum  = sq_ff + 64'(prod_ff);
   assign trial   = {1'b0, res_ff} + {1'b0, bit_ff};
   assign xs      = x_ff >>> cnt_ff[3:0];
   assign ys      = y_ff >>> cnt_ff[3:0];

   // final fold and rounding to Q8.8
   always_comb begin
      if (acc_ff < 0)           acc_cl = '0;
      else if (acc_ff > ACC_90) acc_cl = ACC_90;
      else                      acc_cl = acc_ff;
      acc_fold = neg_ff ? ACC_180 - acc_cl : acc_cl;
      acc_rnd  = $unsigned(acc_fold + 25'sd128) >> 8;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dot_in   = dot_ff;
      t_in     = t_ff;
      sq_in    = sq_ff;
      n_in     = n_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      angle_in = angle_ff;
      done_in  = 1'b0;
      for (int k = 0; k < 3; k++) begin
         ma_in[k]   = ma_ff[k];
         mb_in[k]   = mb_ff[k];
         nega_in[k] = nega_ff[k];
         negb_in[k] = negb_ff[k];
         c_in[k]    = c_ff[k];
      end

      unique case (state_ff)
         A_IDLE: begin
            if (start) begin
               for (int k = 0; k < 3; k++) begin
                  nega_in[k] = base_vec[k][COORD_BITS];
                  negb_in[k] = step_vec[k][COORD_BITS];
                  ma_in[k] = MW'($unsigned(base_vec[k][COORD_BITS] ? -base_vec[k]
                                                                   : base_vec[k]));
                  mb_in[k] = MW'($unsigned(step_vec[k][COORD_BITS] ? -step_vec[k]
                                                                   : step_vec[k]));
               end
               state_in = A_SCALE;
            end
         end
         A_SCALE: begin
            // one bit of right shift per cycle until both vectors fit
            for (int k = 0; k < 3; k++) begin
               if (need_a) ma_in[k] = ma_ff[k] >> 1;
               if (need_b) mb_in[k] = mb_ff[k] >> 1;
            end
            if (!need_a && !need_b) begin
               state_in = A_MUL;
               cnt_in   = '0;
            end
         end
         A_MUL: begin
            // product of op (cnt-1) sits in prod_ff
            case (cnt_ff[3:0])
               4'd1:    dot_in  = DW'(prod_ff);
               4'd2:    dot_in  = dot_ff + DW'(prod_ff);
               4'd3:    dot_in  = dot_ff + DW'(prod_ff);
               4'd4:    t_in    = 32'(prod_ff);
               4'd5:    c_in[0] = t_ff - 32'(prod_ff);
               4'd6:    t_in    = 32'(prod_ff);
               4'd7:    c_in[1] = t_ff - 32'(prod_ff);
               4'd8:    t_in    = 32'(prod_ff);
               4'd9:    c_in[2] = t_ff - 32'(prod_ff);
               4'd10:   sq_in   = 64'(prod_ff);
               4'd11:   sq_in   = sq_sum;
               4'd12:   sq_in   = sq_sum;
               default: ;
            endcase
            if (cnt_ff == 5'd12) begin
               n_in     = sq_sum;
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = A_SQRT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         A_SQRT: begin
            if ({1'b0, n_ff} >= trial) begin
               n_in   = n_ff - trial[63:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               neg_in   = dot_ff < 0;
               x_in     = (dot_ff < 0) ? -XW'(dot_ff) : XW'(dot_ff);
               y_in     = XW'(res_in);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = A_CORDIC;
            end
         end
         A_CORDIC: begin
            if (y_ff == 0 || cnt_ff == 5'(CORDIC_STEPS)) begin
               angle_in = (acc_rnd > ACC_BITS'(ANGLE_MAX)) ? ANGLE_MAX : acc_rnd[15:0];
               done_in  = 1'b1;
               state_in = A_IDLE;
            end else begin
               if (y_ff > 0) begin
                  x_in   = x_ff + ys;
                  y_in   = y_ff - xs;
                  acc_in = acc_ff + $signed(atan_entry(cnt_ff[3:0]));
               end else begin
                  x_in   = x_ff - ys;
                  y_in   = y_ff + xs;
                  acc_in = acc_ff - $signed(atan_entry(cnt_ff[3:0]));
               end
               cnt_in = cnt_ff + 5'd1;
            end
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      dot_ff   <= dot_in;
      t_ff     <= t_in;
      sq_ff    <= sq_in;
      n_ff     <= n_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      angle_ff <= angle_in;
      for (int k = 0; k < 3; k++) begin
         ma_ff[k]   <= ma_in[k];
         mb_ff[k]   <= mb_in[k];
         nega_ff[k] <= nega_in[k];
         negb_ff[k] <= negb_in[k];
         c_ff[k]    <= c_in[k];
      end
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

// ===== src/trajectory_deflection_detector.sv =====
// Top level of the trajectory deflection detector: control sequencer, exact
// cross-sign unit, confidence divider. Depends on tdd_pkg, tdd_if, tdd_angle.
`timescale 1ns / 1ps
// Usage
//  req_if  : one trajectory point per beat (time, x/y/z in Q16.16, last_point).
//  rsp_if  : one result beat per trajectory, sent after the point with last_point.
//  csr_if  : register writes (index 0 angle_threshold, 1 min_point_count); always
//            ready, other indexes are dropped. Write only while the block is idle.
//  Timing  : ready is high only in the idle state; one point at a time.
//   - point that gives no angle (first point, non-rising time, baseline, zero
//     step): idle, then the check state, plus the result path on a last point.
//   - point with an angle: the serial cross-sign unit, then the angle unit with
//     its scale, multiply, square root and CORDIC steps, then the check state.
//     The angle unit has one shared 32x32 multiplier and a one-bit-per-cycle root.
//   - last point with a report and a nonzero threshold: the restoring divider.
//  Result sits in an output register; if the receiver stalls, the block holds it
//  and keeps taking points until the next result needs that register.
//  Reset (synchronous): registers back to 1280 and 8, trajectory state cleared.
module trajectory_deflection_detector #(
   parameter int COORD_BITS = tdd_pkg::COORD_BITS_DEF,
   parameter int TIME_BITS  = tdd_pkg::TIME_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   tdd_req_if.sink    req_if,
   tdd_rsp_if.source  rsp_if,
   tdd_csr_if.sink    csr_if
);
   import tdd_pkg::*;

   localparam int VW = COORD_BITS + 1;          // step width
   localparam int XW = 2 * VW + 2;              // cross accumulator
   localparam int CB = $clog2(VW);              // bit index
   localparam int NB = 36;                      // divider numerator
   localparam int DB = 20;                      // divider denominator

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CROSS = 3'd1;
   localparam logic [2:0] S_AGO   = 3'd2;
   localparam logic [2:0] S_AWAIT = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [15:0]               thr_ff, thr_in, minpts_ff, minpts_in;

   // trajectory state
   logic [15:0]               pcount_ff, pcount_in;
   logic                      have_prev_ff, have_prev_in;
   logic [TIME_BITS-1:0]      prev_time_ff, prev_time_in;
   logic signed [COORD_BITS-1:0] prev_pos_ff [3], prev_pos_in [3];
   logic [1:0]                scount_ff, scount_in;
   logic signed [VW-1:0]      base_ff [3], base_in [3];
   sign_type                  sign_ff, sign_in;
   logic [1:0]                flip_ff, flip_in;
   logic                      lfound_ff, lfound_in;
   logic [TIME_BITS-1:0]      ltime_ff, ltime_in;
   logic [15:0]               langle_ff, langle_in;

   // current point
   logic [TIME_BITS-1:0]      time_ff, time_in;
   logic                      last_ff, last_in;
   logic signed [VW-1:0]      step_ff [3], step_in [3];
   logic signed [VW-1:0]      d_new [3];
   logic signed [COORD_BITS-1:0] p_new [3];
   logic                      d_zero, base_zero, rising;

   // cross-sign unit
   logic signed [XW-1:0]      cross_ff, cross_in, term;
   logic [CB-1:0]             bitcnt_ff, bitcnt_in;
   sign_type                  s_new;

   // angle unit
   logic                      ang_start, ang_done;
   logic [15:0]               ang_val;

   // divider and result staging
   logic [NB-1:0]             dnum_ff, dnum_in;
   logic [DB-1:0]             drem_ff, drem_in, dden_ff, dden_in;
   logic [DB:0]               dtrial;
   logic                      dge;
   logic [5:0]                dcnt_ff, dcnt_in;
   logic                      report, report_ff, report_in;
   logic [15:0]               conf_ff, conf_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      o_found_ff, o_found_in, o_kind_ff, o_kind_in;
   logic [TIME_BITS-1:0]      o_time_ff, o_time_in;
   logic [15:0]               o_angle_ff, o_angle_in, o_conf_ff, o_conf_in;

   assign p_new[0] = req_if.pos_x;
   assign p_new[1] = req_if.pos_y;
   assign p_new[2] = req_if.pos_z;

   always_comb begin
      for (int k = 0; k < 3; k++) d_new[k] = VW'(p_new[k]) - VW'(prev_pos_ff[k]);
      d_zero    = (d_new[0] == 0) && (d_new[1] == 0) && (d_new[2] == 0);
      base_zero = (base_ff[0] == 0) && (base_ff[1] == 0) && (base_ff[2] == 0);
      rising    = have_prev_ff && (req_if.sample_time > prev_time_ff);
   end

   // serial signed multiply, MSB first: acc = bz*vx - bx*vz
   always_comb begin
      term = (step_ff[0][bitcnt_ff] ? XW'(base_ff[2]) : XW'(0))
           - (step_ff[2][bitcnt_ff] ? XW'(base_ff[0]) : XW'(0));
      cross_in = (cross_ff <<< 1) + ((bitcnt_ff == CB'(COORD_BITS)) ? -term : term);
      if (cross_in > 0)      s_new = SIGN_POS;
      else if (cross_in < 0) s_new = SIGN_NEG;
      else                   s_new = SIGN_NONE;
   end

   assign report = lfound_ff && (pcount_ff >= minpts_ff) && (scount_ff == 2'd3)
                   && !base_zero;

   // restoring division, one quotient bit per cycle
   assign dtrial = {drem_ff, dnum_ff[NB-1]};
   assign dge    = dtrial >= {1'b0, dden_ff};

   assign ang_start = (state_ff == S_AGO);

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      minpts_in    = minpts_ff;
      pcount_in    = pcount_ff;
      have_prev_in = have_prev_ff;
      prev_time_in = prev_time_ff;
      scount_in    = scount_ff;
      sign_in      = sign_ff;
      flip_in      = flip_ff;
      lfound_in    = lfound_ff;
      ltime_in     = ltime_ff;
      langle_in    = langle_ff;
      time_in      = time_ff;
      last_in      = last_ff;
      bitcnt_in    = bitcnt_ff;
      dnum_in      = dnum_ff;
      drem_in      = drem_ff;
      dden_in      = dden_ff;
      dcnt_in      = dcnt_ff;
      report_in    = report_ff;
      conf_in      = conf_ff;
      o_found_in   = o_found_ff;
      o_kind_in    = o_kind_ff;
      o_time_in    = o_time_ff;
      o_angle_in   = o_angle_ff;
      o_conf_in    = o_conf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      for (int k = 0; k < 3; k++) begin
         prev_pos_in[k] = prev_pos_ff[k];
         base_in[k]     = base_ff[k];
         step_in[k]     = step_ff[k];
      end

      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_ANGLE_THRESHOLD: thr_in    = csr_if.data;
            REG_MIN_POINT_COUNT: minpts_in = csr_if.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               if (pcount_ff != 16'hFFFF) pcount_in = pcount_ff + 16'd1;
               time_in      = req_if.sample_time;
               last_in      = req_if.last_point;
               prev_time_in = req_if.sample_time;
               have_prev_in = 1'b1;
               for (int k = 0; k < 3; k++) begin
                  prev_pos_in[k] = p_new[k];
                  step_in[k]     = d_new[k];
               end
               state_in = S_CHECK;
               if (rising) begin
                  if (scount_ff == 2'd0) begin
                     for (int k = 0; k < 3; k++) base_in[k] = d_new[k];
                     scount_in = 2'd1;
                  end else begin
                     if (scount_ff != 2'd3) scount_in = scount_ff + 2'd1;
                     if (!base_zero && !d_zero) begin
                        bitcnt_in = CB'(COORD_BITS);
                        state_in  = S_CROSS;
                     end
                  end
               end
            end
         end
         S_CROSS: begin
            if (bitcnt_ff == '0) begin
               if (s_new != SIGN_NONE && sign_ff != SIGN_NONE && s_new != sign_ff
                   && flip_ff != 2'd2)
                  flip_in = flip_ff + 2'd1;
               if (s_new != SIGN_NONE) sign_in = s_new;
               state_in = S_AGO;
            end else begin
               bitcnt_in = bitcnt_ff - CB'(1);
            end
         end
         S_AGO: state_in = S_AWAIT;
         S_AWAIT: begin
            if (ang_done) begin
               if (ang_val > thr_ff && !lfound_ff) begin
                  lfound_in = 1'b1;
                  ltime_in  = time_ff;
                  langle_in = ang_val;
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else begin
               report_in = report;
               if (report && thr_ff != 16'd0) begin
                  // (32768*(6*thr + angle) + 5*thr) / (10*thr)
                  dnum_in  = ((((NB'(thr_ff) << 2) + (NB'(thr_ff) << 1) + NB'(langle_ff))
                             << 15) + (NB'(thr_ff) << 2) + NB'(thr_ff));
                  dden_in  = (DB'(thr_ff) << 3) + (DB'(thr_ff) << 1);
                  drem_in  = '0;
                  dcnt_in  = '0;
                  state_in = S_DIV;
               end else begin
                  conf_in  = report ? CONF_ONE : 16'd0;
                  state_in = S_EMIT;
               end
            end
         end
         S_DIV: begin
            drem_in = dge ? DB'(dtrial - {1'b0, dden_ff}) : DB'(dtrial);
            dnum_in = {dnum_ff[NB-2:0], dge};
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'(NB - 1)) begin
               conf_in  = (dnum_in > NB'(CONF_ONE)) ? CONF_ONE : dnum_in[15:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               o_found_in   = report_ff;
               o_time_in    = report_ff ? ltime_ff : '0;
               o_angle_in   = report_ff ? langle_ff : 16'd0;
               o_kind_in    = report_ff && (flip_ff == 2'd2);
               o_conf_in    = conf_ff;
               // trajectory done: clear its state, keep the registers
               pcount_in    = '0;
               have_prev_in = 1'b0;
               scount_in    = '0;
               sign_in      = SIGN_NONE;
               flip_in      = '0;
               lfound_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THRESH_RESET;
         minpts_ff    <= MINPTS_RESET;
         pcount_ff    <= '0;
         have_prev_ff <= 1'b0;
         scount_ff    <= '0;
         sign_ff      <= SIGN_NONE;
         flip_ff      <= '0;
         lfound_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bitcnt_ff    <= '0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         minpts_ff    <= minpts_in;
         pcount_ff    <= pcount_in;
         have_prev_ff <= have_prev_in;
         scount_ff    <= scount_in;
         sign_ff      <= sign_in;
         flip_ff      <= flip_in;
         lfound_ff    <= lfound_in;
         rsp_valid_ff <= rsp_valid_in;
         bitcnt_ff    <= bitcnt_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_time_ff <= prev_time_in;
      ltime_ff     <= ltime_in;
      langle_ff    <= langle_in;
      time_ff      <= time_in;
      last_ff      <= last_in;
      cross_ff     <= (state_ff == S_CROSS) ? cross_in : XW'(0);
      dnum_ff      <= dnum_in;
      drem_ff      <= drem_in;
      dden_ff      <= dden_in;
      report_ff    <= report_in;
      conf_ff      <= conf_in;
      o_found_ff   <= o_found_in;
      o_kind_ff    <= o_kind_in;
      o_time_ff    <= o_time_in;
      o_angle_ff   <= o_angle_in;
      o_conf_ff    <= o_conf_in;
      for (int k = 0; k < 3; k++) begin
         prev_pos_ff[k] <= prev_pos_in[k];
         base_ff[k]     <= base_in[k];
         step_ff[k]     <= step_in[k];
      end
   end

   tdd_angle #(
      .COORD_BITS (COORD_BITS)
   ) u_angle (
      .clock    (clock),
      .reset    (reset),
      .start    (ang_start),
      .base_vec (base_ff),
      .step_vec (step_ff),
      .done     (ang_done),
      .angle    (ang_val)
   );

   assign req_if.ready         = (state_ff == S_IDLE);
   assign csr_if.ready         = 1'b1;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.anomaly_found = o_found_ff;
   assign rsp_if.anomaly_stamp = o_time_ff;
   assign rsp_if.anomaly_angle = o_angle_ff;
   assign rsp_if.anomaly_kind  = o_kind_ff;
   assign rsp_if.confidence    = o_conf_ff;

endmodule
